FILE: design/ole_pkg.sv
// Shared types, constants and helpers for the ordered list engine.
// No dependencies; imported by every module of the block.
package ole_pkg;

    // list geometry
    localparam int DEPTH  = 64;
    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // stream payload widths
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    // reduction tree: groups of GRP cells, then one combine over NG groups
    localparam int GRP   = 8;
    localparam int NG    = (DEPTH + GRP - 1) / GRP;
    localparam int OFF_W = $clog2(GRP);
    localparam int GRP_W = $clog2(GRP + 1);

    // command codes
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_DELETE = 3'd1;
    localparam logic [2:0] ACT_FIRST  = 3'd2;
    localparam logic [2:0] ACT_LAST   = 3'd3;
    localparam logic [2:0] ACT_COUNT  = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    // per-cell update
    typedef enum logic [1:0] {
        OP_HOLD       = 2'd0,
        OP_TAKE_LEFT  = 2'd1,
        OP_TAKE_RIGHT = 2'd2,
        OP_LOAD_KEY   = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     cmp_en;   // compare against key this cycle
        logic     pick;     // capture own value (delete target)
    } cell_ctrl_t;

    // reduced results over the row of cells
    typedef struct packed {
        logic [CNT_W-1:0]  first;
        logic [CNT_W-1:0]  last;
        logic [CNT_W-1:0]  count;
        logic [DATA_W-1:0] picked;
    } red_t;

    // 32-bit signed input value to stored entry width
    function automatic logic [DATA_W-1:0] to_entry(input logic [31:0] v);
        logic [63:0] ext;
        ext = {{32{v[31]}}, v};
        return ext[DATA_W-1:0];
    endfunction

    // stored entry to the 32-bit result field
    function automatic logic [31:0] from_entry(input logic [DATA_W-1:0] e);
        logic [63:0] z;
        z = 64'(e);
        return z[31:0];
    endfunction

endpackage

FILE: design/ole_cell.sv
// One cell of the list row: holds one entry, shifts with its neighbors.
// Depends on ole_pkg.
module ole_cell import ole_pkg::*; (
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    input  logic [DATA_W-1:0] key,
    output logic [DATA_W-1:0] value_q,
    output logic              match_q,
    output logic [DATA_W-1:0] pick_q
);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              match_reg;
    logic [DATA_W-1:0] pick_reg;

    // entry update from neighbors or key
    always_comb begin
        case (ctrl.op)
            OP_TAKE_LEFT:  value_next = left_val;
            OP_TAKE_RIGHT: value_next = right_val;
            OP_LOAD_KEY:   value_next = key;
            default:       value_next = value_reg;
        endcase
    end

    // entry, match flag and delete capture
    always_ff @(posedge aclk) begin
        value_reg <= value_next;
        match_reg <= ctrl.cmp_en && (value_reg == key);
        pick_reg  <= ctrl.pick ? value_reg : '0;
    end

    assign value_q = value_reg;
    assign match_q = match_reg;
    assign pick_q  = pick_reg;

endmodule

FILE: design/ole_reduce.sv
// Two-level registered reduction over the cell row: first/last match,
// match count and the captured delete value. Depends on ole_pkg.
module ole_reduce import ole_pkg::*; (
    input  logic                         aclk,
    input  logic [DEPTH-1:0]             match,
    input  logic [DEPTH-1:0][DATA_W-1:0] picks,
    output red_t                         red
);

    logic [NG*GRP-1:0]             match_pad;
    logic [NG*GRP-1:0][DATA_W-1:0] picks_pad;

    logic [NG-1:0]             any_reg;
    logic [NG-1:0][OFF_W-1:0]  first_reg;
    logic [NG-1:0][OFF_W-1:0]  last_reg;
    logic [NG-1:0][GRP_W-1:0]  cnt_reg;
    logic [NG-1:0][DATA_W-1:0] pick_reg;

    // pad row to whole groups
    always_comb begin
        match_pad = '0;
        picks_pad = '0;
        match_pad[DEPTH-1:0] = match;
        for (int i = 0; i < DEPTH; i++) begin
            picks_pad[i] = picks[i];
        end
    end

    // level one: per-group results
    always_ff @(posedge aclk) begin
        for (int g = 0; g < NG; g++) begin
            logic              any_v;
            logic [OFF_W-1:0]  first_v;
            logic [OFF_W-1:0]  last_v;
            logic [GRP_W-1:0]  cnt_v;
            logic [DATA_W-1:0] pick_v;
            any_v   = 1'b0;
            first_v = '0;
            last_v  = '0;
            cnt_v   = '0;
            pick_v  = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (match_pad[g*GRP + j]) begin
                    first_v = OFF_W'(j);
                end
            end
            for (int j = 0; j < GRP; j++) begin
                if (match_pad[g*GRP + j]) begin
                    any_v  = 1'b1;
                    last_v = OFF_W'(j);
                    cnt_v  = cnt_v + 1'b1;
                end
                pick_v = pick_v | picks_pad[g*GRP + j];
            end
            any_reg[g]   <= any_v;
            first_reg[g] <= first_v;
            last_reg[g]  <= last_v;
            cnt_reg[g]   <= cnt_v;
            pick_reg[g]  <= pick_v;
        end
    end

    // level two: combine groups, positions are 1-based
    always_comb begin
        red = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (any_reg[g]) begin
                red.first = CNT_W'(g * GRP) + CNT_W'(first_reg[g]) + 1'b1;
            end
        end
        for (int g = 0; g < NG; g++) begin
            if (any_reg[g]) begin
                red.last = CNT_W'(g * GRP) + CNT_W'(last_reg[g]) + 1'b1;
            end
            red.count  = red.count + CNT_W'(cnt_reg[g]);
            red.picked = red.picked | pick_reg[g];
        end
    end

endmodule

FILE: design/ordered_list_engine.sv
// Top level of the ordered list engine: command FSM, row of cells,
// reduction tree and output register. Depends on ole_pkg, ole_cell, ole_reduce.
//
// Keeps an ordered list of up to DEPTH entries in a row of cells, entry i in
// cell i. Insert and delete shift the cells in the same cycle the command beat
// is taken; inserts go from accept straight to the result load. Deletes capture
// the target cell and searches compare in every occupied cell at accept,
// then pass the two-level registered reduction tree in the group and reduce
// states. Errors and empty-list finds skip the reduction. A finished result
// sits in the output register, so the next command is taken while it waits.
// One command is in work at a time; there is no clearing pass after reset.
module ordered_list_engine import ole_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // [2:0] action, [34:3] value, [41:35] position, [47:42] zero
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // [1:0] status, [33:2] removed_value, [40:34] found_index, [47:41] length
    output logic [M_DATA_W-1:0] m_tdata
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_GROUP  = 4'b0010,
        S_REDUCE = 4'b0100,
        S_PUSH   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [2:0]        act_reg;
    logic [1:0]        res_status_reg;
    logic [31:0]       res_removed_reg;
    logic [POS_W-1:0]  res_found_reg;
    logic              m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [2:0]        s_act;
    logic [31:0]       s_val;
    logic [POS_W-1:0]  s_pos;
    logic              s_acc;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  pos_m1;
    logic              full;
    logic              empty;
    logic              ins_ok;
    logic              del_ok;
    logic              srch_go;
    logic              push;
    logic [DATA_W-1:0] key;
    logic [POS_W-1:0]  red_found;

    cell_ctrl_t                   cell_ctrl [DEPTH];
    logic [DEPTH-1:0][DATA_W-1:0] cell_val;
    logic [DEPTH-1:0][DATA_W-1:0] cell_pick;
    logic [DEPTH-1:0]             cell_match;
    red_t                         red;

    // input beat decode
    assign s_act   = s_tdata[2:0];
    assign s_val   = s_tdata[34:3];
    assign s_pos   = s_tdata[41:35];
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc   = s_tvalid && s_tready;
    assign key     = to_entry(s_val);

    assign pos_x  = CMP_W'(s_pos);
    assign cnt_x  = CMP_W'(count_reg);
    assign pos_m1 = pos_x - 1'b1;
    assign full   = cnt_x >= CMP_W'(DEPTH);
    assign empty  = (count_reg == '0);

    assign ins_ok  = (s_act == ACT_INSERT) && !full && (s_pos != '0)
                     && (pos_x <= cnt_x + 1'b1);
    assign del_ok  = (s_act == ACT_DELETE) && !empty && (s_pos != '0)
                     && (pos_x <= cnt_x);
    assign srch_go = (((s_act == ACT_FIRST) || (s_act == ACT_LAST)) && !empty)
                     || (s_act == ACT_COUNT);

    // per-cell control
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cell_ctrl[i].op     = OP_HOLD;
            cell_ctrl[i].cmp_en = s_acc && srch_go && (CMP_W'(i) < cnt_x);
            cell_ctrl[i].pick   = s_acc && del_ok && (CMP_W'(i) == pos_m1);
            if (s_acc && ins_ok) begin
                if (CMP_W'(i) == pos_m1) begin
                    cell_ctrl[i].op = OP_LOAD_KEY;
                end else if (CMP_W'(i) > pos_m1) begin
                    cell_ctrl[i].op = OP_TAKE_LEFT;
                end
            end else if (s_acc && del_ok && (CMP_W'(i) >= pos_m1)) begin
                cell_ctrl[i].op = OP_TAKE_RIGHT;
            end
        end
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] left_v;
        logic [DATA_W-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = '0;
        end else begin : g_left
            assign left_v = cell_val[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_right
            assign right_v = cell_val[i+1];
        end
        ole_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[i]),
            .left_val  (left_v),
            .right_val (right_v),
            .key       (key),
            .value_q   (cell_val[i]),
            .match_q   (cell_match[i]),
            .pick_q    (cell_pick[i])
        );
    end

    ole_reduce u_reduce (
        .aclk  (aclk),
        .match (cell_match),
        .picks (cell_pick),
        .red   (red)
    );

    // select reduced result by command
    always_comb begin
        case (act_reg)
            ACT_FIRST: red_found = POS_W'(red.first);
            ACT_LAST:  red_found = POS_W'(red.last);
            ACT_COUNT: red_found = POS_W'(red.count);
            default:   red_found = '0;
        endcase
    end

    assign push = (state_reg == S_PUSH) && (!m_tvalid_reg || m_tready);

    // command sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = (del_ok || srch_go) ? S_GROUP : S_PUSH;
                end
            end
            S_GROUP:  state_next = S_REDUCE;
            S_REDUCE: state_next = S_PUSH;
            S_PUSH: begin
                if (push) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (s_acc && ins_ok) begin
                count_reg <= count_reg + 1'b1;
            end else if (s_acc && del_ok) begin
                count_reg <= count_reg - 1'b1;
            end
            if (push) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            act_reg         <= s_act;
            res_removed_reg <= '0;
            res_found_reg   <= '0;
            res_status_reg  <= STAT_OK;
            case (s_act)
                ACT_INSERT: begin
                    if (full) begin
                        res_status_reg <= STAT_FULL;
                    end else if (!ins_ok) begin
                        res_status_reg <= STAT_RANGE;
                    end
                end
                ACT_DELETE: begin
                    if (empty) begin
                        res_status_reg <= STAT_EMPTY;
                    end else if (!del_ok) begin
                        res_status_reg <= STAT_RANGE;
                    end
                end
                ACT_FIRST, ACT_LAST: begin
                    if (empty) begin
                        res_status_reg <= STAT_EMPTY;
                    end
                end
                default: ;
            endcase
        end else if (state_reg == S_REDUCE) begin
            res_removed_reg <= from_entry(red.picked);
            res_found_reg   <= red_found;
        end
        if (push) begin
            m_tdata_reg <= {POS_W'(count_reg), res_found_reg,
                            res_removed_reg, res_status_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(count_reg) <= CMP_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && ins_ok) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the list by one");

    a_delete_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && del_ok) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("delete did not shrink the list by one");

    a_push_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> m_tvalid)
        else $error("result load did not raise m_tvalid");

    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (del_ok || srch_go)) |=> !s_tready ##1 !s_tready)
        else $error("new beat taken while reduction in flight");

endmodule
